@@ design/kmf_pkg.sv @@
// Shared widths, constants and control types for the minmod flux stencil pipeline.
package kmf_pkg;

  // Field widths fixed by the stream format.
  localparam int VW = 18;   // velocity samples
  localparam int QW = 32;   // conserved-variable samples
  localparam int TW = 18;   // limiter parameter theta
  localparam int HW = 32;   // face fluxes
  localparam int SW = 18;   // propagation speed

  localparam int IN_TDATA_W  = 256;
  localparam int OUT_TDATA_W = 88;
  localparam int OUT_PAD     = OUT_TDATA_W - (2 * HW + SW);

  localparam logic [TW-1:0] THETA_RESET = 18'd117965;
  localparam logic [SW-1:0] SPEED_CAP   = 18'd131072;

  localparam logic signed [HW-1:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [HW-1:0] SAT_MIN = 32'sh8000_0000;

  // Pipeline stages, in order of travel.
  localparam int ST_DIFF  = 0;
  localparam int ST_PROD  = 1;
  localparam int ST_SLOPE = 2;
  localparam int ST_FACE  = 3;
  localparam int ST_SUM   = 4;
  localparam int ST_MUL   = 5;
  localparam int ST_OUT   = 6;
  localparam int NSTG     = 7;

  typedef struct packed {
    logic [NSTG-1:0] adv;   // stage k loads from stage k-1 this cycle
  } kmf_ctl_t;

endpackage

@@ design/kmf_pipe_ctrl.sv @@
// Valid tracking and per-stage load enables for the flux stencil pipeline.
module kmf_pipe_ctrl
  import kmf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  output kmf_ctl_t ctl_o
);

  logic [NSTG-1:0] valid_r;
  logic [NSTG-1:0] valid_nxt;
  logic [NSTG:0]   en;
  logic            in_fire;
  logic            out_fire;

  // A stage may load when it is empty or when the stage after it moves on,
  // so bubbles close up while the output is stalled.
  always_comb begin
    en[NSTG] = out_tready;
    for (int k = NSTG - 1; k >= 0; k--) begin
      en[k] = !valid_r[k] || en[k+1];
    end
  end

  always_comb begin
    valid_nxt[0] = en[0] ? in_tvalid : valid_r[0];
    for (int k = 1; k < NSTG; k++) begin
      valid_nxt[k] = en[k] ? valid_r[k-1] : valid_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign ctl_o.adv  = en[NSTG-1:0];
  assign in_tready  = en[0];
  assign out_tvalid = valid_r[NSTG-1];
  assign in_fire    = in_tvalid && in_tready;
  assign out_fire   = out_tvalid && out_tready;

`ifndef SYNTHESIS
  a_bubble_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !(&valid_r) |-> in_tready)
    else $error("pipeline has an empty stage but refuses input");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (&valid_r) && !out_tready |-> !in_tready)
    else $error("full pipeline accepted an item while the output stalled");

  a_item_count: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> $countones(valid_r) ==
             $countones($past(valid_r)) + $past(in_fire) - $past(out_fire))
    else $error("items lost or duplicated inside the pipeline");
`endif

endmodule

@@ design/kmf_slope.sv @@
// Three-stage limited-slope unit for one five-point stencil.
module kmf_slope
  import kmf_pkg::*;
#(
  parameter int W         = 18,
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  kmf_ctl_t            ctl_i,
  input  logic [TW-1:0]       theta_i,
  input  logic signed [W-1:0] mm_i,
  input  logic signed [W-1:0] m_i,
  input  logic signed [W-1:0] c_i,
  input  logic signed [W-1:0] p_i,
  input  logic signed [W-1:0] pp_i,
  output logic signed [W-1:0] slope_m_o,
  output logic signed [W-1:0] slope_c_o,
  output logic signed [W-1:0] slope_p_o,
  output logic signed [W-1:0] m_o,
  output logic signed [W-1:0] c_o,
  output logic signed [W-1:0] p_o
);

  localparam int DW = W + 1;            // neighbor differences
  localparam int PW = TW + 1 + DW;      // theta times a difference

  function automatic logic signed [PW-1:0] minmod(input logic signed [PW-1:0] x,
                                                  input logic signed [PW-1:0] y);
    logic signed [PW-1:0] res;
    res = '0;
    if (x > 0 && y > 0) begin
      res = (x < y) ? x : y;
    end else if (x < 0 && y < 0) begin
      res = (x > y) ? x : y;
    end
    return res;
  endfunction

  logic signed [DW-1:0] d0_r, d1_r, d2_r, d3_r;
  logic signed [W-1:0]  h0m_r, h0c_r, h0p_r;
  logic signed [W-1:0]  m0_r, c0_r, p0_r;
  logic signed [DW-1:0] wide_m, wide_c, wide_p;

  logic signed [PW-1:0] t0_r, t1_r, t2_r, t3_r;
  logic signed [W-1:0]  h1m_r, h1c_r, h1p_r;
  logic signed [W-1:0]  m1_r, c1_r, p1_r;
  logic signed [TW:0]   theta_s;

  logic signed [W-1:0]  sm_r, sc_r, sp_r;
  logic signed [W-1:0]  m2_r, c2_r, p2_r;

  // Half of the two-cell difference: drop the low bit of the wide difference.
  assign wide_m  = DW'(c_i) - DW'(mm_i);
  assign wide_c  = DW'(p_i) - DW'(m_i);
  assign wide_p  = DW'(pp_i) - DW'(c_i);
  assign theta_s = $signed({1'b0, theta_i});

  always_ff @(posedge clk) begin
    if (ctl_i.adv[ST_DIFF]) begin
      d0_r  <= DW'(m_i) - DW'(mm_i);
      d1_r  <= DW'(c_i) - DW'(m_i);
      d2_r  <= DW'(p_i) - DW'(c_i);
      d3_r  <= DW'(pp_i) - DW'(p_i);
      h0m_r <= wide_m[DW-1:1];
      h0c_r <= wide_c[DW-1:1];
      h0p_r <= wide_p[DW-1:1];
      m0_r  <= m_i;
      c0_r  <= c_i;
      p0_r  <= p_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.adv[ST_PROD]) begin
      t0_r  <= (PW'(theta_s) * PW'(d0_r)) >>> FRAC_BITS;
      t1_r  <= (PW'(theta_s) * PW'(d1_r)) >>> FRAC_BITS;
      t2_r  <= (PW'(theta_s) * PW'(d2_r)) >>> FRAC_BITS;
      t3_r  <= (PW'(theta_s) * PW'(d3_r)) >>> FRAC_BITS;
      h1m_r <= h0m_r;
      h1c_r <= h0c_r;
      h1p_r <= h0p_r;
      m1_r  <= m0_r;
      c1_r  <= c0_r;
      p1_r  <= p0_r;
    end
  end

  // The limited slope never exceeds the half difference in magnitude,
  // so it fits the sample width.
  always_ff @(posedge clk) begin
    if (ctl_i.adv[ST_SLOPE]) begin
      sm_r <= W'(minmod(t0_r, minmod(PW'(h1m_r), t1_r)));
      sc_r <= W'(minmod(t1_r, minmod(PW'(h1c_r), t2_r)));
      sp_r <= W'(minmod(t2_r, minmod(PW'(h1p_r), t3_r)));
      m2_r <= m1_r;
      c2_r <= c1_r;
      p2_r <= p1_r;
    end
  end

  assign slope_m_o = sm_r;
  assign slope_c_o = sc_r;
  assign slope_p_o = sp_r;
  assign m_o       = m2_r;
  assign c_o       = c2_r;
  assign p_o       = p2_r;

endmodule

@@ design/kmf_flux.sv @@
// Four-stage face reconstruction, current and central-flux datapath.
module kmf_flux
  import kmf_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  kmf_ctl_t             ctl_i,
  input  logic signed [VW-1:0] dvm_i,
  input  logic signed [VW-1:0] dv_i,
  input  logic signed [VW-1:0] dvp_i,
  input  logic signed [VW-1:0] vm_i,
  input  logic signed [VW-1:0] v_i,
  input  logic signed [VW-1:0] vp_i,
  input  logic signed [QW-1:0] dqm_i,
  input  logic signed [QW-1:0] dq_i,
  input  logic signed [QW-1:0] dqp_i,
  input  logic signed [QW-1:0] qm_i,
  input  logic signed [QW-1:0] q_i,
  input  logic signed [QW-1:0] qp_i,
  output logic signed [HW-1:0] hp_o,
  output logic signed [HW-1:0] hm_o,
  output logic [SW-1:0]        speed_o
);

  localparam int FPW  = QW + VW;        // q times v products
  localparam int FW   = FPW + 1;        // face currents
  localparam int SMW  = FW + 1;         // sum of two face currents
  localparam int VFW  = VW + 1;         // velocity face values and speeds
  localparam int QFW  = QW + 1;         // conserved face values
  localparam int QDW  = QFW + 1;        // jump across a face
  localparam int MW   = VFW + 1 + QDW;  // speed times jump
  localparam int DFW  = MW + 1;         // flux before halving

  function automatic logic [VFW-1:0] mag(input logic signed [VFW-1:0] x);
    return x[VFW-1] ? VFW'(-x) : VFW'(x);
  endfunction

  function automatic logic signed [HW-1:0] sat(input logic signed [DFW-1:0] x);
    logic signed [HW-1:0] res;
    res = HW'(x);
    if (x > DFW'(SAT_MAX)) begin
      res = SAT_MAX;
    end else if (x < DFW'(SAT_MIN)) begin
      res = SAT_MIN;
    end
    return res;
  endfunction

  // Face stage.
  logic signed [FPW-1:0] fm_r, fc_r, fp_r;
  logic signed [FPW-1:0] pqp_r, pvp_r, pqc_r, pvc_r, pqm_r, pvm_r;
  logic signed [VFW-1:0] vrp_r, vlp_r, vrm_r, vlm_r;
  logic signed [QFW-1:0] qrp_r, qlp_r, qrm_r, qlm_r;

  // Sum stage.
  logic [VFW-1:0]        sp_r, sm_r, s4_r;
  logic [VFW-1:0]        sp_nxt, sm_nxt;
  logic signed [QDW-1:0] qdp_r, qdm_r;
  logic signed [FW-1:0]  cc;
  logic signed [FW-1:0]  frp_r, flp_r, frm_r, flm_r;

  // Multiply stage.
  logic signed [MW-1:0]  mp_r, mm_r;
  logic signed [SMW-1:0] sump_r, summ_r;
  logic [VFW-1:0]        s5_r;

  // Output stage.
  logic signed [DFW-1:0] hp_full, hm_full;
  logic signed [HW-1:0]  hp_r, hm_r;
  logic [SW-1:0]         speed_r;

  always_ff @(posedge clk) begin
    if (ctl_i.adv[ST_FACE]) begin
      fm_r  <= (FPW'(qm_i) * FPW'(vm_i)) >>> FRAC_BITS;
      fc_r  <= (FPW'(q_i) * FPW'(v_i)) >>> FRAC_BITS;
      fp_r  <= (FPW'(qp_i) * FPW'(vp_i)) >>> FRAC_BITS;
      pqp_r <= (FPW'(qp_i) * FPW'(dvp_i)) >>> FRAC_BITS;
      pvp_r <= (FPW'(vp_i) * FPW'(dqp_i)) >>> FRAC_BITS;
      pqc_r <= (FPW'(q_i) * FPW'(dv_i)) >>> FRAC_BITS;
      pvc_r <= (FPW'(v_i) * FPW'(dq_i)) >>> FRAC_BITS;
      pqm_r <= (FPW'(qm_i) * FPW'(dvm_i)) >>> FRAC_BITS;
      pvm_r <= (FPW'(vm_i) * FPW'(dqm_i)) >>> FRAC_BITS;
      vrp_r <= VFW'(vp_i) - VFW'(dvp_i >>> 1);
      vlp_r <= VFW'(v_i) + VFW'(dv_i >>> 1);
      vrm_r <= VFW'(v_i) - VFW'(dv_i >>> 1);
      vlm_r <= VFW'(vm_i) + VFW'(dvm_i >>> 1);
      qrp_r <= QFW'(qp_i) - QFW'(dqp_i >>> 1);
      qlp_r <= QFW'(q_i) + QFW'(dq_i >>> 1);
      qrm_r <= QFW'(q_i) - QFW'(dq_i >>> 1);
      qlm_r <= QFW'(qm_i) + QFW'(dqm_i >>> 1);
    end
  end

  always_comb begin
    sp_nxt = (mag(vlp_r) > mag(vrp_r)) ? mag(vlp_r) : mag(vrp_r);
    sm_nxt = (mag(vlm_r) > mag(vrm_r)) ? mag(vlm_r) : mag(vrm_r);
    cc     = (FW'(pqc_r) + FW'(pvc_r)) >>> 1;
  end

  always_ff @(posedge clk) begin
    if (ctl_i.adv[ST_SUM]) begin
      sp_r  <= sp_nxt;
      sm_r  <= sm_nxt;
      s4_r  <= (sp_nxt > sm_nxt) ? sp_nxt : sm_nxt;
      qdp_r <= QDW'(qrp_r) - QDW'(qlp_r);
      qdm_r <= QDW'(qrm_r) - QDW'(qlm_r);
      frp_r <= FW'(fp_r) - ((FW'(pqp_r) + FW'(pvp_r)) >>> 1);
      flp_r <= FW'(fc_r) + cc;
      frm_r <= FW'(fc_r) - cc;
      flm_r <= FW'(fm_r) + ((FW'(pqm_r) + FW'(pvm_r)) >>> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.adv[ST_MUL]) begin
      mp_r   <= (MW'($signed({1'b0, sp_r})) * MW'(qdp_r)) >>> FRAC_BITS;
      mm_r   <= (MW'($signed({1'b0, sm_r})) * MW'(qdm_r)) >>> FRAC_BITS;
      sump_r <= SMW'(frp_r) + SMW'(flp_r);
      summ_r <= SMW'(frm_r) + SMW'(flm_r);
      s5_r   <= s4_r;
    end
  end

  always_comb begin
    hp_full = (DFW'(sump_r) - DFW'(mp_r)) >>> 1;
    hm_full = (DFW'(summ_r) - DFW'(mm_r)) >>> 1;
  end

  always_ff @(posedge clk) begin
    if (ctl_i.adv[ST_OUT]) begin
      hp_r    <= sat(hp_full);
      hm_r    <= sat(hm_full);
      speed_r <= (s5_r > VFW'(SPEED_CAP)) ? SPEED_CAP : SW'(s5_r);
    end
  end

  assign hp_o    = hp_r;
  assign hm_o    = hm_r;
  assign speed_o = speed_r;

endmodule

@@ design/kt_minmod_flux_stencil.sv @@
// Top level of the Kurganov-Tadmor minmod flux stencil pipeline.
//
// Each input item carries a five-point stencil of one conserved variable q and
// the matching five-point velocity stencil v along one axis, all in signed
// fixed point with FRAC_BITS fraction bits. The block forms theta-scaled
// three-way minmod slopes, reconstructs the face values and chain-rule
// currents, and returns the central numerical fluxes at the plus and minus
// half faces together with the largest local propagation speed for the CFL
// limit. The block holds no state besides the theta register, so items are
// independent. It takes one item per clock unless every stage is full and
// out_tready is low, and passes it through a seven-stage pipeline: neighbor
// differences, theta products, minmod selection, face values with the nine
// q-times-v products, face currents and speeds, the speed-times-jump
// products, and final halving with saturation in the output register. Each
// stage moves on when it is empty or when the stage after it moves, so a
// stalled output still lets new items fill the empty stages behind it, and
// in_tready falls only when every stage holds an item and out_tready is low.
// Fluxes clamp to the signed 32-bit range and the speed clamps to 2.0.
// Theta resets to about 1.8; the user must write it through cfg_we and
// cfg_wdata only while no item is in flight; the block does not enforce this.
module kt_minmod_flux_stencil
  import kmf_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // in_tdata fields from bit 0 up: v_center, v_minus2, v_minus, v_plus,
  // v_plus2 (18 bits each), q_center, q_minus2, q_minus, q_plus, q_plus2
  // (32 bits each), then zero padding.
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // out_tdata fields from bit 0 up: hp_flux (32 bits), hm_flux (32 bits),
  // max_speed (18 bits), then zero padding.
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic                   cfg_we,
  input  logic [TW-1:0]          cfg_wdata
);

  logic [TW-1:0] theta_r;

  logic signed [VW-1:0] v_center, v_minus2, v_minus, v_plus, v_plus2;
  logic signed [QW-1:0] q_center, q_minus2, q_minus, q_plus, q_plus2;

  logic signed [VW-1:0] dvm, dv, dvp, vm_s, v_s, vp_s;
  logic signed [QW-1:0] dqm, dq, dqp, qm_s, q_s, qp_s;

  logic signed [HW-1:0] hp_flux, hm_flux;
  logic [SW-1:0]        max_speed;

  kmf_ctl_t ctl;

  // The user must write the limiter register only with the pipeline empty (unchecked).
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      theta_r <= THETA_RESET;
    end else if (cfg_we) begin
      theta_r <= cfg_wdata;
    end
  end

  assign v_center = in_tdata[17:0];
  assign v_minus2 = in_tdata[35:18];
  assign v_minus  = in_tdata[53:36];
  assign v_plus   = in_tdata[71:54];
  assign v_plus2  = in_tdata[89:72];
  assign q_center = in_tdata[121:90];
  assign q_minus2 = in_tdata[153:122];
  assign q_minus  = in_tdata[185:154];
  assign q_plus   = in_tdata[217:186];
  assign q_plus2  = in_tdata[249:218];

  kmf_pipe_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .ctl_o      (ctl)
  );

  // The velocity and conserved-variable slopes run side by side in the
  // first three stages.
  kmf_slope #(
    .W         (VW),
    .FRAC_BITS (FRAC_BITS)
  ) u_vslope (
    .clk       (clk),
    .ctl_i     (ctl),
    .theta_i   (theta_r),
    .mm_i      (v_minus2),
    .m_i       (v_minus),
    .c_i       (v_center),
    .p_i       (v_plus),
    .pp_i      (v_plus2),
    .slope_m_o (dvm),
    .slope_c_o (dv),
    .slope_p_o (dvp),
    .m_o       (vm_s),
    .c_o       (v_s),
    .p_o       (vp_s)
  );

  kmf_slope #(
    .W         (QW),
    .FRAC_BITS (FRAC_BITS)
  ) u_qslope (
    .clk       (clk),
    .ctl_i     (ctl),
    .theta_i   (theta_r),
    .mm_i      (q_minus2),
    .m_i       (q_minus),
    .c_i       (q_center),
    .p_i       (q_plus),
    .pp_i      (q_plus2),
    .slope_m_o (dqm),
    .slope_c_o (dq),
    .slope_p_o (dqp),
    .m_o       (qm_s),
    .c_o       (q_s),
    .p_o       (qp_s)
  );

  // The last four stages build the face fluxes; their final register is the
  // output register of the block.
  kmf_flux #(
    .FRAC_BITS (FRAC_BITS)
  ) u_flux (
    .clk     (clk),
    .ctl_i   (ctl),
    .dvm_i   (dvm),
    .dv_i    (dv),
    .dvp_i   (dvp),
    .vm_i    (vm_s),
    .v_i     (v_s),
    .vp_i    (vp_s),
    .dqm_i   (dqm),
    .dq_i    (dq),
    .dqp_i   (dqp),
    .qm_i    (qm_s),
    .q_i     (q_s),
    .qp_i    (qp_s),
    .hp_o    (hp_flux),
    .hm_o    (hm_flux),
    .speed_o (max_speed)
  );

  assign out_tdata = {{OUT_PAD{1'b0}}, max_speed, hm_flux, hp_flux};

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the Kurganov-Tadmor minmod flux stencil pipeline.
module tb_top;
  import kmf_pkg::*;

  localparam int FRAC_BITS   = 16;
  localparam int PIPE_DEPTH  = 7;        // pipeline stages in the DUT
  localparam int CYCLE_LIMIT = 200000;   // watchdog limit for the whole run

  localparam longint QMAX = 64'sd2147483647;
  localparam longint QMIN = -64'sd2147483648;
  localparam longint VMAX = 64'sd131071;
  localparam longint VMIN = -64'sd131072;
  localparam longint UNIT = 64'sd65536;  // 1.0 in Q16.16

  // One stencil as it travels on in_tdata, in signed fixed point.
  typedef struct packed {
    logic signed [VW-1:0] vc, vmm, vm, vp, vpp;
    logic signed [QW-1:0] qc, qmm, qm, qp, qpp;
  } stencil_t;

  // The three result fields carried by one out_tdata item.
  typedef struct packed {
    logic signed [HW-1:0] hp;
    logic signed [HW-1:0] hm;
    logic [SW-1:0]        speed;
  } flux_result_t;

  logic                   clk;
  logic                   rst_n;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic                   cfg_we;
  logic [TW-1:0]          cfg_wdata;

  // Fluxes predicted for accepted items, oldest first.
  flux_result_t  pending_fluxes[$];
  flux_result_t  due;
  logic [TW-1:0] theta_model;     // our copy of the limiter register
  bit            idle_on;         // random idle bursts on both sides
  int            hold_cycles = 0; // a long receiver stall requested by a test
  int            errors = 0;
  int            cycle_count = 0;

  kt_minmod_flux_stencil #(
    .FRAC_BITS(FRAC_BITS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // ---------------------------------------------------------------------------
  // Flux predictor. Every value lives in a 64-bit signed intermediate, which is
  // wide enough for any input pattern. Products and halvings round toward
  // minus infinity, which is exactly what an arithmetic right shift does.
  // ---------------------------------------------------------------------------
  function automatic longint fx_mul(longint a, longint b);
    return (a * b) >>> FRAC_BITS;
  endfunction

  // Two-way minmod: the smaller magnitude when the signs agree, else zero.
  function automatic longint minmod(longint x, longint y);
    if (x > 0 && y > 0) return (x < y) ? x : y;
    if (x < 0 && y < 0) return (x > y) ? x : y;
    return 0;
  endfunction

  // Theta-scaled three-way minmod slope at b, with a behind and c ahead.
  function automatic longint limited_slope(longint a, longint b, longint c, longint th);
    return minmod(fx_mul(th, b - a), minmod((c - a) >>> 1, fx_mul(th, c - b)));
  endfunction

  function automatic longint magnitude(longint x);
    return (x < 0) ? -x : x;
  endfunction

  function automatic longint larger(longint a, longint b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic signed [HW-1:0] sat_flux(longint x);
    if (x > longint'(SAT_MAX)) return SAT_MAX;
    if (x < longint'(SAT_MIN)) return SAT_MIN;
    return x[HW-1:0];
  endfunction

  function automatic flux_result_t kt_face_fluxes(stencil_t s, logic [TW-1:0] theta_reg);
    longint th, v, vmm, vm, vp, vpp, q, qmm, qm, qp, qpp;
    longint dvp, dv, dvm, vrp, vlp, vrm, vlm, sp, sm, smax;
    longint dqp, dq, dqm, qrp, qlp, qrm, qlm;
    longint f_m, f_c, f_p, chain, frp, flp, frm, flm;
    flux_result_t r;
    th  = longint'(theta_reg);   // unsigned register, zero extended
    v   = s.vc;
    vmm = s.vmm;
    vm  = s.vm;
    vp  = s.vp;
    vpp = s.vpp;
    q   = s.qc;
    qmm = s.qmm;
    qm  = s.qm;
    qp  = s.qp;
    qpp = s.qpp;

    // Velocity slopes, face values and local propagation speeds.
    dvp  = limited_slope(v, vp, vpp, th);
    dv   = limited_slope(vm, v, vp, th);
    dvm  = limited_slope(vmm, vm, v, th);
    vrp  = vp - (dvp >>> 1);
    vlp  = v + (dv >>> 1);
    vrm  = v - (dv >>> 1);
    vlm  = vm + (dvm >>> 1);
    sp   = larger(magnitude(vlp), magnitude(vrp));
    sm   = larger(magnitude(vlm), magnitude(vrm));
    smax = larger(sp, sm);

    // Conserved-variable slopes and face values.
    dqp = limited_slope(q, qp, qpp, th);
    dq  = limited_slope(qm, q, qp, th);
    dqm = limited_slope(qmm, qm, q, th);
    qrp = qp - (dqp >>> 1);
    qlp = q + (dq >>> 1);
    qrm = q - (dq >>> 1);
    qlm = qm + (dqm >>> 1);

    // Cell currents and their chain-rule extrapolation to the faces.
    f_m   = fx_mul(qm, vm);
    f_c   = fx_mul(q, v);
    f_p   = fx_mul(qp, vp);
    chain = (fx_mul(q, dv) + fx_mul(v, dq)) >>> 1;
    frp   = f_p - ((fx_mul(qp, dvp) + fx_mul(vp, dqp)) >>> 1);
    flp   = f_c + chain;
    frm   = f_c - chain;
    flm   = f_m + ((fx_mul(qm, dvm) + fx_mul(vm, dqm)) >>> 1);

    // The unclamped speeds enter the fluxes; only the reported one is capped.
    r.hp    = sat_flux((frp + flp - fx_mul(sp, qrp - qlp)) >>> 1);
    r.hm    = sat_flux((frm + flm - fx_mul(sm, qrm - qlm)) >>> 1);
    r.speed = (smax > longint'(SPEED_CAP)) ? SPEED_CAP : smax[SW-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  // Builds a stencil from values in spatial order; each value is cut to its
  // field width, so wide random words exercise every bit of every field.
  function automatic stencil_t stencil_at(longint vmm, longint vm, longint vc, longint vp,
                                          longint vpp, longint qmm, longint qm, longint qc,
                                          longint qp, longint qpp);
    stencil_t s;
    s.vmm = vmm[VW-1:0];
    s.vm  = vm[VW-1:0];
    s.vc  = vc[VW-1:0];
    s.vp  = vp[VW-1:0];
    s.vpp = vpp[VW-1:0];
    s.qmm = qmm[QW-1:0];
    s.qm  = qm[QW-1:0];
    s.qc  = qc[QW-1:0];
    s.qp  = qp[QW-1:0];
    s.qpp = qpp[QW-1:0];
    return s;
  endfunction

  function automatic logic [IN_TDATA_W-1:0] pack_stencil(stencil_t s);
    return {{(IN_TDATA_W - 5 * VW - 5 * QW){1'b0}},
            s.qpp, s.qp, s.qm, s.qmm, s.qc, s.vpp, s.vp, s.vm, s.vmm, s.vc};
  endfunction

  function automatic longint clip(longint x, longint lo, longint hi);
    return (x < lo) ? lo : ((x > hi) ? hi : x);
  endfunction

  function automatic longint corner_q();
    case ($urandom_range(0, 4))
      0: return QMAX;
      1: return QMIN;
      2: return 0;
      3: return -1;
      default: return 1;
    endcase
  endfunction

  function automatic longint corner_v();
    case ($urandom_range(0, 5))
      0: return VMAX;
      1: return VMIN;
      2: return UNIT;
      3: return -UNIT;
      4: return 0;
      default: return -1;
    endcase
  endfunction

  // Most stencils are smooth profiles with random offset, gradient and noise,
  // so the limiter sees agreeing slopes; the rest are raw bits or corner values.
  function automatic stencil_t rand_stencil();
    longint va[5];
    longint qa[5];
    longint qb, qs, vb, vs;
    case ($urandom_range(0, 9))
      0, 1: begin
        for (int k = 0; k < 5; k++) begin
          va[k] = longint'($urandom);
          qa[k] = longint'($urandom);
        end
      end
      2: begin
        for (int k = 0; k < 5; k++) begin
          va[k] = corner_v();
          qa[k] = corner_q();
        end
      end
      default: begin
        qb = longint'($signed($urandom)) >>> $urandom_range(0, 6);
        qs = longint'($signed($urandom)) >>> $urandom_range(3, 31);
        vb = longint'($urandom_range(0, 131072)) - UNIT;
        vs = (longint'($urandom_range(0, 65536)) - 32768) >>> $urandom_range(0, 8);
        for (int k = 0; k < 5; k++) begin
          qa[k] = clip(qb + (k - 2) * qs
                       + (longint'($signed($urandom)) >>> $urandom_range(10, 31)),
                       QMIN, QMAX);
          va[k] = clip(vb + (k - 2) * vs + longint'($urandom_range(0, 64)) - 32,
                       -UNIT, UNIT);
        end
      end
    endcase
    return stencil_at(va[0], va[1], va[2], va[3], va[4], qa[0], qa[1], qa[2], qa[3], qa[4]);
  endfunction

  // ---------------------------------------------------------------------------
  // Handshake tasks. Inputs change on the falling edge; handshakes are judged
  // on the rising edge, so nothing depends on event order within a step.
  // ---------------------------------------------------------------------------

  // Offers one item, optionally after an idle burst, and records its fluxes
  // at the edge where it is accepted.
  task automatic send_stencil(input stencil_t s);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_tdata  = pack_stencil(s);
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    pending_fluxes.push_back(kt_face_fluxes(s, theta_model));
  endtask

  task automatic send_random(input int count);
    repeat (count) send_stencil(rand_stencil());
  endtask

  // Stops offering and waits until every predicted result has come back.
  task automatic wait_fluxes_out();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_fluxes.size() != 0) @(posedge clk);
  endtask

  // Theta is only written with the pipeline empty.
  task automatic set_theta(input logic [TW-1:0] value);
    wait_fluxes_out();
    @(negedge clk);
    cfg_we      = 1'b1;
    cfg_wdata   = value;
    theta_model = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Directed stencils at the reset theta: field extremes, both saturation
  // directions of the fluxes, limiter sign cases and floor rounding.
  task automatic test_directed_corners();
    // Flat zero field.
    send_stencil(stencil_at(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // Flat extremes: q times v far outside 32 bits, fluxes clamp high and low.
    send_stencil(stencil_at(VMAX, VMAX, VMAX, VMAX, VMAX, QMAX, QMAX, QMAX, QMAX, QMAX));
    send_stencil(stencil_at(VMIN, VMIN, VMIN, VMIN, VMIN, QMAX, QMAX, QMAX, QMAX, QMAX));
    send_stencil(stencil_at(VMAX, VMAX, VMAX, VMAX, VMAX, QMIN, QMIN, QMIN, QMIN, QMIN));
    send_stencil(stencil_at(VMIN, VMIN, VMIN, VMIN, VMIN, QMIN, QMIN, QMIN, QMIN, QMIN));
    // Alternating extremes: every slope is a local extremum, so all limit to zero.
    send_stencil(stencil_at(VMAX, VMIN, VMAX, VMIN, VMAX, QMAX, QMIN, QMAX, QMIN, QMAX));
    send_stencil(stencil_at(VMIN, VMAX, VMIN, VMAX, VMIN, QMIN, QMAX, QMIN, QMAX, QMIN));
    // Full-range monotone ramps, rising and falling.
    send_stencil(stencil_at(-UNIT, -32768, 0, 32768, UNIT,
                            QMIN, -64'sd1073741824, 0, 64'sd1073741824, QMAX));
    send_stencil(stencil_at(UNIT, 32768, 0, -32768, -UNIT,
                            QMAX, 64'sd1073741824, 0, -64'sd1073741824, QMIN));
    // Velocity exactly at plus and minus one over a gentle q ramp.
    send_stencil(stencil_at(UNIT, UNIT, UNIT, UNIT, UNIT, 100, 200, 300, 400, 500));
    send_stencil(stencil_at(-UNIT, -UNIT, -UNIT, -UNIT, -UNIT, 500, 400, 300, 200, 100));
    // A peak in q: the center slope sees opposite signs and goes to zero.
    send_stencil(stencil_at(0, 1000, 2000, 1000, 0, 0, 1000, 1000000, 1000, 0));
    // Tiny negative values where rounding toward minus infinity matters.
    send_stencil(stencil_at(-1, -2, -1, -3, -1, -1, -3, -2, -5, -1));
    send_stencil(stencil_at(1, -1, 1, -1, 1, 1, -1, 2, -3, 5));
    // Velocity beyond one in magnitude is taken as given.
    send_stencil(stencil_at(VMIN, VMAX, 64'sd98304, -64'sd98304, VMAX,
                            64'sd65536, 64'sd131072, 64'sd196608, 64'sd131072, 64'sd65536));
  endtask

  // Random stencils across the limiter range, its ends and values outside it.
  // Theta just below 4.0 lets a face overshoot its neighbor, which is the one
  // way to push the reported speed past its cap; both signs are hit directly.
  task automatic test_theta_sweep();
    set_theta(18'd65536);
    send_random(25);
    set_theta(18'd131072);
    send_random(25);
    set_theta(18'h3FFFF);
    send_stencil(stencil_at(VMIN, VMIN, 64'sd131000, VMAX, VMAX, 0, 0, 0, 0, 0));
    send_stencil(stencil_at(VMAX, VMAX, -64'sd131000, VMIN, VMIN, 0, 0, 0, 0, 0));
    send_random(25);
    set_theta(18'd0);
    send_random(25);
    set_theta(TW'($urandom_range(0, 2 ** TW - 1)));
    send_random(25);
    set_theta(TW'($urandom_range(65536, 131072)));
    send_random(25);
  endtask

  // The receiver stalls long enough for every stage to fill while the sender
  // keeps offering, so in_tready must drop and recover without losing items.
  task automatic test_backpressure();
    wait_fluxes_out();
    idle_on     = 1'b0;
    hold_cycles = 60;
    send_random(40);
    idle_on = 1'b1;
  endtask

  // Long random stream over several theta settings; the last stretch runs
  // at full rate on both sides.
  task automatic test_random_stream();
    set_theta(THETA_RESET);
    send_random(60);
    for (int p = 0; p < 3; p++) begin
      set_theta(TW'($urandom_range(65536, 131072)));
      send_random(60);
    end
    idle_on = 1'b0;
    send_random(60);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: ready with random idle bursts, plus one long stall on request.
  // ---------------------------------------------------------------------------
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_tready = 1'b0;
        repeat (hold_cycles - 1) @(negedge clk);
        hold_cycles = 0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_tready = 1'b0;
        repeat ($urandom_range(0, 6)) @(negedge clk);
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: every accepted item is compared with the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_fluxes.size() == 0) begin
        $display("%0t: unexpected result item, got %h", $time, out_tdata);
        errors++;
      end else begin
        due = pending_fluxes.pop_front();
        if (out_tdata[HW-1:0] !== due.hp) begin
          $display("%0t: hp_flux expected %0d, got %0d",
                   $time, due.hp, $signed(out_tdata[HW-1:0]));
          errors++;
        end
        if (out_tdata[2*HW-1:HW] !== due.hm) begin
          $display("%0t: hm_flux expected %0d, got %0d",
                   $time, due.hm, $signed(out_tdata[2*HW-1:HW]));
          errors++;
        end
        if (out_tdata[2*HW+SW-1:2*HW] !== due.speed) begin
          $display("%0t: max_speed expected %0d, got %0d",
                   $time, due.speed, out_tdata[2*HW+SW-1:2*HW]);
          errors++;
        end
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_fluxes.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, the tests in turn, then a drain and the verdict.
  // ---------------------------------------------------------------------------
  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    theta_model = THETA_RESET;
    idle_on     = 1'b1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_corners();
    test_theta_sweep();
    test_backpressure();
    test_random_stream();

    // Let any stray item surface before judging.
    wait_fluxes_out();
    repeat (PIPE_DEPTH + 8) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
